// File: rtl/first_fit_block_run_allocator_assert.svh
// Assertion helpers for the run allocator, clocked on clock, off in reset.
`ifndef FIRST_FIT_BLOCK_RUN_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_RUN_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFA_ASSERT_IMP(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("allocator assertion failed");

// next-cycle implication
`define FFA_ASSERT_NXT(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("allocator assertion failed");

`endif

// File: rtl/ffa_pkg.sv
package ffa_pkg;

   localparam int NUM_BLOCKS = 256;
   localparam int IDX_W      = $clog2(NUM_BLOCKS);
   localparam int LEN_W      = IDX_W + 1;
   localparam int CNT_W      = 9;
   localparam int CMP_W      = (LEN_W > CNT_W) ? LEN_W : CNT_W;
   localparam int ADDR_W     = 48;
   localparam int SHIFT_W    = 4;
   localparam int RSV_W      = 8;
   localparam int FREE_W     = 9;
   localparam int ENT_W      = LEN_W + 1;   // {busy, length}

   localparam logic [1:0] OP_INIT  = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;

   localparam logic [1:0] CSR_BASE     = 2'd0;
   localparam logic [1:0] CSR_SHIFT    = 2'd1;
   localparam logic [1:0] CSR_RESERVED = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT0,
      ST_INIT1,
      ST_A_RD,
      ST_A_CHK,
      ST_A_MRG,
      ST_A_FIT,
      ST_A_SPLIT,
      ST_F_OFF,
      ST_F_IDX,
      ST_F_RD,
      ST_F_CHK,
      ST_F_MRG,
      ST_F_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  base;
      logic [SHIFT_W-1:0] shift;
      logic [RSV_W-1:0]   reserved;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [CNT_W-1:0]  count;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] block_address;
      logic [FREE_W-1:0] free_blocks;
   } res_type;

endpackage

// File: rtl/ffa_ram.sv
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/ffa_core.sv
module ffa_core (
   input  logic              clock,
   input  logic              reset,
   input  ffa_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffa_pkg::req_type  req,
   output logic              res_valid,
   input  logic              res_ready,
   output ffa_pkg::res_type  res
);

   localparam int NB  = ffa_pkg::NUM_BLOCKS;
   localparam int IW  = ffa_pkg::IDX_W;
   localparam int LW  = ffa_pkg::LEN_W;
   localparam int CW  = ffa_pkg::CMP_W;
   localparam int AW  = ffa_pkg::ADDR_W;

   ffa_pkg::state_type state_ff, state_in;
   logic [1:0]                  op_ff, op_in;
   logic [ffa_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [AW-1:0]               addr_ff, addr_in;
   logic [LW-1:0]               p_ff, p_in;
   logic [IW-1:0]               idx_ff, idx_in;
   logic [LW-1:0]               len_ff, len_in;
   logic [LW-1:0]               free_ff, free_in;
   logic                        ok_ff, ok_in;
   logic                        boot_ff, boot_in;
   logic [NB-1:0]               valid_ff;
   logic                        vrd_ff;

   logic                        ram_we;
   logic [IW-1:0]               ram_waddr, ram_raddr;
   logic [ffa_pkg::ENT_W-1:0]   ram_wdata, ram_rdata;
   logic                        clr_all, clr_en;
   logic [IW-1:0]               clr_addr;

   logic [LW-1:0]  rd_len;
   logic           rd_busy;
   logic [LW-1:0]  nx_sum, mrg_sum, r_len, cnt_len;
   logic [15:0]    rsv_w;
   logic [AW-1:0]  shifted;

   ffa_ram #(.WIDTH(ffa_pkg::ENT_W), .DEPTH(NB)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // entries never written since init read as empty
   assign rd_len  = vrd_ff ? ram_rdata[LW-1:0] : '0;
   assign rd_busy = vrd_ff & ram_rdata[LW];
   assign nx_sum  = p_ff + rd_len;
   assign mrg_sum = p_ff + len_ff;
   assign cnt_len = LW'(count_ff);
   assign shifted = addr_ff >> cfg.shift;

   always_comb begin
      rsv_w = 16'(cfg.reserved);
      if (rsv_w == 16'd0) begin
         rsv_w = 16'd1;
      end else if (rsv_w > 16'(NB)) begin
         rsv_w = 16'(NB);
      end
   end
   assign r_len = rsv_w[LW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffa_pkg::ST_INIT0;
         boot_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         boot_ff  <= boot_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      count_ff <= count_in;
      addr_ff  <= addr_in;
      p_ff     <= p_in;
      idx_ff   <= idx_in;
      len_ff   <= len_in;
      free_ff  <= free_in;
      ok_ff    <= ok_in;
      vrd_ff   <= valid_ff[ram_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset || clr_all) begin
         valid_ff <= '0;
      end else begin
         if (clr_en) begin
            valid_ff[clr_addr] <= 1'b0;
         end
         if (ram_we) begin
            valid_ff[ram_waddr] <= 1'b1;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      boot_in   = boot_ff;
      op_in     = op_ff;
      count_in  = count_ff;
      addr_in   = addr_ff;
      p_in      = p_ff;
      idx_in    = idx_ff;
      len_in    = len_ff;
      free_in   = free_ff;
      ok_in     = ok_ff;
      ram_we    = 1'b0;
      ram_waddr = p_ff[IW-1:0];
      ram_wdata = '0;
      ram_raddr = p_ff[IW-1:0];
      clr_all   = 1'b0;
      clr_en    = 1'b0;
      clr_addr  = mrg_sum[IW-1:0];
      req_ready = 1'b0;
      res_valid = 1'b0;

      unique case (state_ff)
         ffa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req.op;
               count_in = req.count;
               addr_in  = req.address;
               p_in     = '0;
               ok_in    = 1'b0;
               unique case (req.op)
                  ffa_pkg::OP_INIT: begin
                     clr_all  = 1'b1;
                     state_in = ffa_pkg::ST_INIT0;
                  end
                  ffa_pkg::OP_ALLOC: begin
                     state_in = (req.count == '0) ? ffa_pkg::ST_DONE : ffa_pkg::ST_A_RD;
                  end
                  ffa_pkg::OP_FREE: state_in = ffa_pkg::ST_F_OFF;
                  default:          state_in = ffa_pkg::ST_DONE;
               endcase
            end
         end
         ffa_pkg::ST_INIT0: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = {1'b1, r_len};
            free_in   = LW'(NB) - r_len;
            ok_in     = 1'b1;
            if (r_len < LW'(NB)) begin
               state_in = ffa_pkg::ST_INIT1;
            end else begin
               state_in = boot_ff ? ffa_pkg::ST_IDLE : ffa_pkg::ST_DONE;
               boot_in  = 1'b0;
            end
         end
         ffa_pkg::ST_INIT1: begin
            ram_we    = 1'b1;
            ram_waddr = r_len[IW-1:0];
            ram_wdata = {1'b0, LW'(NB) - r_len};
            state_in  = boot_ff ? ffa_pkg::ST_IDLE : ffa_pkg::ST_DONE;
            boot_in   = 1'b0;
         end
         ffa_pkg::ST_A_RD: begin
            state_in = (p_ff >= LW'(NB)) ? ffa_pkg::ST_DONE : ffa_pkg::ST_A_CHK;
         end
         ffa_pkg::ST_A_CHK: begin
            if (rd_len == '0) begin
               state_in = ffa_pkg::ST_DONE;
            end else if (rd_busy) begin
               p_in     = nx_sum;
               state_in = ffa_pkg::ST_A_RD;
            end else begin
               len_in    = rd_len;
               ram_raddr = nx_sum[IW-1:0];
               state_in  = (nx_sum < LW'(NB)) ? ffa_pkg::ST_A_MRG : ffa_pkg::ST_A_FIT;
            end
         end
         ffa_pkg::ST_A_MRG: begin
            if (rd_len != '0 && !rd_busy) begin
               clr_en = 1'b1;
               len_in = len_ff + rd_len;
            end
            state_in = ffa_pkg::ST_A_FIT;
         end
         ffa_pkg::ST_A_FIT: begin
            ram_we = 1'b1;
            if (CW'(count_ff) < CW'(len_ff)) begin
               ram_wdata = {1'b1, cnt_len};
               state_in  = ffa_pkg::ST_A_SPLIT;
            end else if (CW'(count_ff) == CW'(len_ff)) begin
               ram_wdata = {1'b1, len_ff};
               free_in   = free_ff - len_ff;
               ok_in     = 1'b1;
               state_in  = ffa_pkg::ST_DONE;
            end else begin
               ram_wdata = {1'b0, len_ff};   // keeps any merge done here
               p_in      = mrg_sum;
               state_in  = ffa_pkg::ST_A_RD;
            end
         end
         ffa_pkg::ST_A_SPLIT: begin
            ram_we    = 1'b1;
            ram_waddr = IW'(p_ff + cnt_len);
            ram_wdata = {1'b0, len_ff - cnt_len};
            free_in   = free_ff - cnt_len;
            ok_in     = 1'b1;
            state_in  = ffa_pkg::ST_DONE;
         end
         ffa_pkg::ST_F_OFF: begin
            if (addr_ff < cfg.base) begin
               state_in = ffa_pkg::ST_DONE;
            end else begin
               addr_in  = addr_ff - cfg.base;
               state_in = ffa_pkg::ST_F_IDX;
            end
         end
         ffa_pkg::ST_F_IDX: begin
            if (shifted >= AW'(NB)) begin
               state_in = ffa_pkg::ST_DONE;
            end else begin
               idx_in   = shifted[IW-1:0];
               p_in     = '0;
               state_in = ffa_pkg::ST_F_RD;
            end
         end
         ffa_pkg::ST_F_RD: begin
            state_in = (p_ff > LW'(idx_ff)) ? ffa_pkg::ST_DONE : ffa_pkg::ST_F_CHK;
         end
         ffa_pkg::ST_F_CHK: begin
            if (p_ff < LW'(idx_ff)) begin
               if (rd_len == '0) begin
                  state_in = ffa_pkg::ST_DONE;
               end else begin
                  p_in     = nx_sum;
                  state_in = ffa_pkg::ST_F_RD;
               end
            end else if (!rd_busy || rd_len == '0) begin
               state_in = ffa_pkg::ST_DONE;
            end else begin
               ram_we    = 1'b1;
               ram_wdata = {1'b0, rd_len};
               free_in   = free_ff + rd_len;
               len_in    = rd_len;
               ok_in     = 1'b1;
               ram_raddr = nx_sum[IW-1:0];
               state_in  = (nx_sum < LW'(NB)) ? ffa_pkg::ST_F_MRG : ffa_pkg::ST_DONE;
            end
         end
         ffa_pkg::ST_F_MRG: begin
            if (rd_len != '0 && !rd_busy) begin
               clr_en   = 1'b1;
               len_in   = len_ff + rd_len;
               state_in = ffa_pkg::ST_F_WR;
            end else begin
               state_in = ffa_pkg::ST_DONE;
            end
         end
         ffa_pkg::ST_F_WR: begin
            ram_we    = 1'b1;
            ram_wdata = {1'b0, len_ff};
            state_in  = ffa_pkg::ST_DONE;
         end
         ffa_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ffa_pkg::ST_IDLE;
            end
         end
         default: state_in = ffa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      res.ok          = ok_ff;
      res.free_blocks = ffa_pkg::FREE_W'(free_ff);
      if (ok_ff && op_ff == ffa_pkg::OP_ALLOC) begin
         res.block_address = cfg.base + (AW'(p_ff[IW-1:0]) << cfg.shift);
      end else begin
         res.block_address = '0;
      end
   end

endmodule

// File: rtl/first_fit_block_run_allocator.sv
// First-fit block run allocator, one operation at a time, result registered.
// Init writes the reserved head run and the free run behind it; allocate reads the run
// heads in turn from the run table, merging a following free run, until one fits;
// free walks the heads before the target, then may merge the next free run into it.
// Throughput: the next request is taken the cycle after the result is registered.
// Reset (sync, active high) clears the valid bits and rebuilds the runs.
`include "first_fit_block_run_allocator_assert.svh"

module first_fit_block_run_allocator (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [8:0] count, [56:9] address, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [47:0] block_address, [56:48] free_blocks
   output logic [0:0]  rsp_tuser,   // [0] ok
   // register writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   ffa_pkg::cfg_type cfg_ff;
   ffa_pkg::req_type req;
   ffa_pkg::res_type res, rsp_ff;
   logic             rsp_valid_ff;
   logic             res_valid, res_ready;

   // config registers; index 3 is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base     <= '0;
         cfg_ff.shift    <= 4'd6;
         cfg_ff.reserved <= 8'd1;
      end else if (csr_we) begin
         case (csr_index)
            ffa_pkg::CSR_BASE:     cfg_ff.base     <= csr_wdata;
            ffa_pkg::CSR_SHIFT:    cfg_ff.shift    <= csr_wdata[ffa_pkg::SHIFT_W-1:0];
            ffa_pkg::CSR_RESERVED: cfg_ff.reserved <= csr_wdata[ffa_pkg::RSV_W-1:0];
            default: ;
         endcase
      end
   end

   assign req.op      = req_tuser;
   assign req.count   = req_tdata[8:0];
   assign req.address = req_tdata[56:9];

   // sequencer plus run table
   ffa_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // output register: the core may start the next transfer while this waits
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.ok;
   assign rsp_tdata  = {7'd0, rsp_ff.free_blocks, rsp_ff.block_address};

   // an accepted item leaves the sequencer busy in the cycle after it
   `FFA_ASSERT_NXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   // a result is loaded only into a free or draining output register
   `FFA_ASSERT_IMP(a_load_when_free, res_valid && res_ready, !rsp_valid_ff || rsp_tready)
   // failed operations never report an address
   `FFA_ASSERT_IMP(a_fail_no_addr, rsp_tvalid && !rsp_tuser[0], rsp_tdata[47:0] == 48'd0)
   // free count cannot exceed the table
   `FFA_ASSERT_IMP(a_free_bound, rsp_tvalid,
      rsp_tdata[56:48] <= ffa_pkg::FREE_W'(ffa_pkg::NUM_BLOCKS))

endmodule

// File: tb/tb.sv
module tb;

   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [8:0] count, [56:9] address
   logic [1:0]  req_tuser = ffa_pkg::OP_INIT; // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // [47:0] block_address, [56:48] free_blocks
   logic [0:0]  rsp_tuser;        // [0] ok
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = ffa_pkg::CSR_BASE;
   logic [47:0] csr_wdata = '0;

   first_fit_block_run_allocator dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // shadow of the run table and registers
   logic [8:0]  run_len [ffa_pkg::NUM_BLOCKS];
   logic        run_busy [ffa_pkg::NUM_BLOCKS];
   int unsigned free_cnt;
   logic [47:0] base_q = '0;
   logic [3:0]  shift_q = 4'd6;
   logic [7:0]  rsv_q = 8'd1;

   ffa_pkg::res_type pending [$];
   int          err_count = 0;
   int          cycles = 0;
   bit          hold_rsp = 1'b0;   // long receiver hold-off request

   // allocated addresses not yet freed, reused as free targets
   logic [47:0] live_addr [$];

   function automatic void build_runs();
      int unsigned r;
      r = (rsv_q == 0) ? 1 : rsv_q;
      if (r > ffa_pkg::NUM_BLOCKS) r = ffa_pkg::NUM_BLOCKS;
      for (int i = 0; i < ffa_pkg::NUM_BLOCKS; i++) begin
         run_len[i] = '0;
         run_busy[i] = 1'b0;
      end
      run_len[0] = 9'(r);
      run_busy[0] = 1'b1;
      if (r < ffa_pkg::NUM_BLOCKS) run_len[r] = 9'(ffa_pkg::NUM_BLOCKS - r);
      free_cnt = ffa_pkg::NUM_BLOCKS - r;
   endfunction

   function automatic void join_next(int unsigned p);
      int unsigned nx;
      nx = p + run_len[p];
      if (nx < ffa_pkg::NUM_BLOCKS && !run_busy[nx] && run_len[nx] != 0) begin
         run_len[p] = run_len[p] + run_len[nx];
         run_len[nx] = '0;
      end
   endfunction

   function automatic ffa_pkg::res_type allocator_next(logic [1:0] op, logic [8:0] cnt,
                                                       logic [47:0] addr);
      ffa_pkg::res_type res;
      int unsigned p, len, idx;
      logic [47:0] off;
      bit          hit;
      res = '0;
      hit = 1'b0;
      if (op == ffa_pkg::OP_INIT) begin
         build_runs();
         res.ok = 1'b1;
      end else if (op == ffa_pkg::OP_ALLOC && cnt != 0) begin
         p = 0;
         while (p < ffa_pkg::NUM_BLOCKS && !hit) begin
            len = run_len[p];
            if (len == 0) break;
            if (!run_busy[p]) begin
               join_next(p);
               len = run_len[p];
               if (cnt <= len) begin
                  // split off the tail as a new free run
                  if (cnt < len) begin
                     run_len[p + cnt] = 9'(len - cnt);
                     run_busy[p + cnt] = 1'b0;
                     run_len[p] = cnt;
                  end
                  run_busy[p] = 1'b1;
                  free_cnt -= cnt;
                  res.ok = 1'b1;
                  res.block_address = base_q + (48'(p) << shift_q);
                  hit = 1'b1;
               end
            end
            if (!hit) p += len;
         end
      end else if (op == ffa_pkg::OP_FREE && addr >= base_q) begin
         off = (addr - base_q) >> shift_q;
         if (off < ffa_pkg::NUM_BLOCKS) begin
            idx = 32'(off);
            p = 0;
            while (p < idx && run_len[p] != 0) p += run_len[p];
            if (p == idx && run_busy[idx] && run_len[idx] != 0) begin
               run_busy[idx] = 1'b0;
               free_cnt += run_len[idx];
               join_next(idx);
               res.ok = 1'b1;
            end
         end
      end
      res.free_blocks = free_cnt[8:0];
      return res;
   endfunction

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      repeat (n) @(negedge clock);
   endtask

   // one request transfer; queues the predicted result
   task automatic send_req(logic [1:0] op, logic [8:0] cnt, logic [47:0] addr);
      ffa_pkg::res_type r;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'd0, addr, cnt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = allocator_next(op, cnt, addr);
      pending.push_back(r);
      if (r.ok && op == ffa_pkg::OP_ALLOC) live_addr.push_back(r.block_address);
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic drain();
      while (pending.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [47:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == ffa_pkg::CSR_BASE) base_q = val;
      else if (idx == ffa_pkg::CSR_SHIFT) shift_q = val[3:0];
      else rsv_q = val[7:0];
   endtask

   // receiver: random stalls plus one long hold-off
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            for (n = 0; n < 3000; n++) @(negedge clock);
            hold_rsp = 1'b0;
         end
         n = $urandom_range(0, 15);
         rsp_tready <= (n > 4) || (n == 0 && cycles[9]);
      end
   end

   // result checker
   always @(posedge clock) begin
      ffa_pkg::res_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending.size() == 0) begin
            err_count++;
            if (err_count <= 10) $display("unexpected result transfer %h", rsp_tdata);
         end else begin
            e = pending.pop_front();
            if (rsp_tuser[0] !== e.ok || rsp_tdata[47:0] !== e.block_address
                || rsp_tdata[56:48] !== e.free_blocks) begin
               err_count++;
               if (err_count <= 10)
                  $display("mismatch: exp ok %b addr %h free %0d, got ok %b addr %h free %0d",
                           e.ok, e.block_address, e.free_blocks, rsp_tuser[0],
                           rsp_tdata[47:0], rsp_tdata[56:48]);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 20000000) begin
         $display("first_fit_block_run_allocator regression: fail");
         $finish;
      end
   end

   typedef struct {
      logic [1:0]  op;
      logic [8:0]  cnt;
      logic [47:0] addr;
      bit          known;   // row carries a hand-typed result
      ffa_pkg::res_type want;
   } row_type;

   row_type dir_rows [$];

   function automatic row_type mk(logic [1:0] op, logic [8:0] cnt, logic [47:0] addr,
                                  bit known = 0, logic ok = 0, logic [47:0] ba = 0,
                                  logic [8:0] fb = 0);
      row_type r;
      r.op = op; r.cnt = cnt; r.addr = addr; r.known = known;
      r.want.ok = ok; r.want.block_address = ba; r.want.free_blocks = fb;
      return r;
   endfunction

   initial begin
      ffa_pkg::res_type got;
      logic [1:0]  op;
      logic [8:0]  cnt;
      logic [47:0] addr;
      int          k;
      build_runs();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, reset config: base 0, 64-byte blocks, one reserved
      dir_rows.push_back(mk(ffa_pkg::OP_ALLOC, 9'd0, 48'd0, 1, 0, 0, 9'd255));  // zero count
      dir_rows.push_back(mk(ffa_pkg::OP_ALLOC, 9'd1, 48'd0, 1, 1, 48'd64, 9'd254));
      dir_rows.push_back(mk(ffa_pkg::OP_ALLOC, 9'd256, 48'd0, 1, 0, 0, 9'd254)); // no fit
      dir_rows.push_back(mk(ffa_pkg::OP_ALLOC, 9'd511, 48'd0, 1, 0, 0, 9'd254));
      dir_rows.push_back(mk(ffa_pkg::OP_ALLOC, 9'd10, 48'd0));
      dir_rows.push_back(mk(ffa_pkg::OP_FREE, 9'd0, 48'd64));
      dir_rows.push_back(mk(ffa_pkg::OP_FREE, 9'd0, 48'd64, 1, 0, 0, 9'd245)); // already free
      dir_rows.push_back(mk(ffa_pkg::OP_FREE, 9'd0, 48'd192));                  // not a head
      dir_rows.push_back(mk(ffa_pkg::OP_FREE, 9'd0, 48'd16384));                // past end
      dir_rows.push_back(mk(ffa_pkg::OP_FREE, 9'd0, 48'hFFFF_FFFF_FFFF));
      dir_rows.push_back(mk(OP_UNKNOWN, 9'd511, 48'hFFFF_FFFF_FFFF));           // unknown op
      dir_rows.push_back(mk(ffa_pkg::OP_ALLOC, 9'd5, 48'd0));                   // skip small hole
      dir_rows.push_back(mk(ffa_pkg::OP_FREE, 9'd0, 48'd0));                    // reserved run
      dir_rows.push_back(mk(ffa_pkg::OP_ALLOC, 9'd1, 48'd0));
      dir_rows.push_back(mk(ffa_pkg::OP_INIT, 9'd0, 48'd0, 1, 1, 0, 9'd255));
      dir_rows.push_back(mk(ffa_pkg::OP_ALLOC, 9'd255, 48'd0, 1, 1, 48'd64, 9'd0));
      dir_rows.push_back(mk(ffa_pkg::OP_ALLOC, 9'd1, 48'd0, 1, 0, 0, 9'd0));
      dir_rows.push_back(mk(ffa_pkg::OP_FREE, 9'd0, 48'd64, 1, 1, 0, 9'd255));
      foreach (dir_rows[i]) begin
         send_req(dir_rows[i].op, dir_rows[i].cnt, dir_rows[i].addr);
         if (dir_rows[i].known) begin
            got = pending[$];
            if (got != dir_rows[i].want) begin
               err_count++;
               if (err_count <= 10) $display("table row %0d disagrees with predictor", i);
            end
         end
      end
      drain();

      // random phases across several register settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph) inside
            1: begin
               write_reg(ffa_pkg::CSR_BASE, 48'hFFFF_FFFF_FFFF);
               write_reg(ffa_pkg::CSR_SHIFT, 48'd12);
               write_reg(ffa_pkg::CSR_RESERVED, 48'd255);
            end
            2: begin
               write_reg(ffa_pkg::CSR_BASE, 48'd0);
               write_reg(ffa_pkg::CSR_SHIFT, 48'd0);
               write_reg(ffa_pkg::CSR_RESERVED, 48'd0);
            end
            3: begin
               write_reg(ffa_pkg::CSR_SHIFT, 48'd15);
               write_reg(ffa_pkg::CSR_RESERVED, 48'd200);
               write_reg(ffa_pkg::CSR_BASE, 48'hA5A5_5A5A_0000);
            end
            4, 5, 6, 7: begin
               write_reg(ffa_pkg::CSR_BASE, 48'({$urandom, $urandom}));
               write_reg(ffa_pkg::CSR_SHIFT, 48'($urandom_range(4, 12)));
               write_reg(ffa_pkg::CSR_RESERVED, 48'($urandom_range(1, 255)));
            end
            default: ;
         endcase
         send_req(ffa_pkg::OP_INIT, 9'($urandom), 48'($urandom));
         live_addr.delete();
         for (k = 0; k < 200; k++) begin
            if (ph == 2 && k == 50) begin
               // fill the block while the receiver holds off
               hold_rsp = 1'b1;
            end
            if (ph == 4 && k == 100) drain();
            case ($urandom_range(0, 9)) inside
               0, 1, 2, 3: begin
                  op = ffa_pkg::OP_ALLOC;
                  cnt = ($urandom_range(0, 15) == 0) ? 9'($urandom) : 9'($urandom_range(1, 12));
                  addr = 48'({$urandom, $urandom});
               end
               4, 5, 6: begin
                  op = ffa_pkg::OP_FREE;
                  cnt = 9'($urandom);
                  if (live_addr.size() != 0) begin
                     int j;
                     j = $urandom_range(0, live_addr.size() - 1);
                     addr = live_addr[j];
                     live_addr.delete(j);
                  end else addr = base_q;
               end
               7: begin
                  op = ffa_pkg::OP_FREE;
                  cnt = 9'($urandom);
                  addr = 48'({$urandom, $urandom});
                  if ($urandom_range(0, 1)) addr = base_q + 48'($urandom_range(0, 300) << shift_q);
               end
               8: begin
                  op = 2'($urandom);
                  cnt = 9'($urandom);
                  addr = 48'({$urandom, $urandom});
               end
               default: begin
                  op = ($urandom_range(0, 3) == 0) ? ffa_pkg::OP_INIT : ffa_pkg::OP_ALLOC;
                  cnt = 9'($urandom_range(1, 256));
                  addr = 48'({$urandom, $urandom});
               end
            endcase
            if (op == ffa_pkg::OP_INIT) live_addr.delete();
            send_req(op, cnt, addr);
            if (!hold_rsp) idle_gap();
         end
         drain();
      end

      drain();
      if (err_count == 0) begin
         $display("first_fit_block_run_allocator regression: pass");
      end else begin
         $display("first_fit_block_run_allocator regression: fail");
      end
      $finish;
   end

endmodule
